>>> sv/cassette_block_deframer_defines.svh
// assertion helpers for the cassette block deframer
// both sample on clk and stay quiet while arst_n is low
`ifndef CASSETTE_BLOCK_DEFRAMER_DEFINES_SVH
`define CASSETTE_BLOCK_DEFRAMER_DEFINES_SVH

// consequent must hold in the same cycle
`define CBD_CHECK_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CBD_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/cbd_pkg.sv
package cbd_pkg;

	// register reset values
	localparam logic [7:0] PILOT_RESET = 8'h01;
	localparam logic [7:0] SYNC1_RESET = 8'h3C;
	localparam logic [7:0] SYNC2_RESET = 8'h5A;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_PILOT = 2'd0;
	localparam logic [1:0] REG_SYNC1 = 2'd1;
	localparam logic [1:0] REG_SYNC2 = 2'd2;

	// event codes
	localparam logic [2:0] EV_PAYLOAD   = 3'd0;
	localparam logic [2:0] EV_COMPLETE  = 3'd1;
	localparam logic [2:0] EV_TRUNCATED = 3'd2;
	localparam logic [2:0] EV_CORRUPT   = 3'd3;
	localparam logic [2:0] EV_TAPE_END  = 3'd4;

	// block types and length codes
	localparam logic [7:0] TYPE_HEADER = 8'h00;
	localparam logic [7:0] TYPE_EOF    = 8'hFF;
	localparam logic [7:0] LEN_FULL    = 8'h00;
	localparam logic [7:0] LEN_BAD     = 8'h01;
	localparam logic [7:0] CNT_FULL    = 8'd254;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// one result word
	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  block_type;
		logic [7:0]  payload_byte;
		logic [7:0]  payload_index;
		logic [7:0]  payload_count;
		logic        checksum_good;
		logic        orphan;
		logic        in_file;
		logic [15:0] file_index;
		logic        last_of_run;
	} rec_t;

	// all results caused by one tape byte
	typedef struct packed {
		logic [1:0]     cnt;
		rec_t [2:0]     rec;
	} bundle_t;

	// front to queue
	typedef struct packed {
		logic    push;
		bundle_t data;
	} q_wr_t;

	// queue status
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

>>> sv/cbd_if.sv
// tape byte channel
interface cbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] tape_byte;
	logic       tape_end;

	modport source (output valid, output tape_byte, output tape_end, input ready);
	modport sink (input valid, input tape_byte, input tape_end, output ready);
endinterface

// result channel
interface cbd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [7:0]  block_type;
	logic [7:0]  payload_byte;
	logic [7:0]  payload_index;
	logic [7:0]  payload_count;
	logic        checksum_good;
	logic        orphan;
	logic        in_file;
	logic [15:0] file_index;
	logic        last_of_run;

	modport source (output valid, output event_res, output block_type, output payload_byte,
		output payload_index, output payload_count, output checksum_good, output orphan,
		output in_file, output file_index, output last_of_run, input ready);
	modport sink (input valid, input event_res, input block_type, input payload_byte,
		input payload_index, input payload_count, input checksum_good, input orphan,
		input in_file, input file_index, input last_of_run, output ready);
endinterface

>>> sv/cbd_queue.sv
module cbd_queue
	import cbd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  q_wr_t   wr,
	input  logic    pop,
	output bundle_t head,
	output q_stat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t       mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (wr.push && !pop) count_q <= count_q + CW'(1);
			else if (!wr.push && pop) count_q <= count_q - CW'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr.push) mem_q[wr_ptr_q] <= wr.data;
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

>>> sv/cbd_front.sv
module cbd_front
	import cbd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] pilot_value,
	input  logic [7:0] sync_first,
	input  logic [7:0] sync_second,
	cbd_in_if.sink     in_ch,
	input  q_stat_t    stat,
	output q_wr_t      wr
);

	localparam logic [2:0] PH_SEARCH = 3'd0;
	localparam logic [2:0] PH_TYPE   = 3'd1;
	localparam logic [2:0] PH_LEN    = 3'd2;
	localparam logic [2:0] PH_DATA   = 3'd3;
	localparam logic [2:0] PH_CHECK  = 3'd4;

	logic [2:0]  phase_q, phase_n;
	logic [7:0]  win_q [3];
	logic [7:0]  win_n [3];
	logic [1:0]  fill_q, fill_n;
	logic [7:0]  type_q, type_n;
	logic [7:0]  left_q, left_n;
	logic [7:0]  pos_q, pos_n;
	logic [7:0]  sum_q, sum_n;
	logic        open_q, open_n;
	logic [15:0] fcnt_q, fcnt_n;

	bundle_t     bun;
	logic [1:0]  nr;
	logic        trunc;
	logic        hit;
	logic        accept;
	logic [7:0]  b;
	logic        tend;
	logic [7:0]  cnt;

	function automatic rec_t mk(input logic [2:0] ev, input logic [7:0] btype,
		input logic [7:0] pb, input logic [7:0] pidx, input logic [7:0] pcnt,
		input logic good, input logic orph, input logic inf, input logic [15:0] fidx);
		rec_t r;
		r.event_res     = ev;
		r.block_type    = btype;
		r.payload_byte  = pb;
		r.payload_index = pidx;
		r.payload_count = pcnt;
		r.checksum_good = good;
		r.orphan        = orph;
		r.in_file       = inf;
		r.file_index    = inf ? fidx : 16'd0;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

	assign in_ch.ready = !stat.full;
	assign accept      = in_ch.valid && !stat.full;
	assign b           = in_ch.tape_byte;
	assign tend        = in_ch.tape_end;

	// classify one byte: next state and its results
	always_comb begin
		phase_n = phase_q;
		win_n   = win_q;
		fill_n  = fill_q;
		type_n  = type_q;
		left_n  = left_q;
		pos_n   = pos_q;
		sum_n   = sum_q;
		open_n  = open_q;
		fcnt_n  = fcnt_q;
		bun     = '0;
		nr      = 2'd0;
		trunc   = 1'b0;
		hit     = 1'b0;
		cnt     = 8'd0;

		unique case (phase_q)
			PH_TYPE: begin
				type_n  = b;
				phase_n = PH_LEN;
				if (tend && open_q) begin
					bun.rec[nr] = mk(EV_CORRUPT, b, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1, fcnt_n);
					nr = nr + 2'd1;
				end
			end
			PH_LEN: begin
				if (b == LEN_BAD) begin
					if (open_q) begin
						bun.rec[nr] = mk(EV_CORRUPT, type_q, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0,
							1'b1, fcnt_n);
						nr = nr + 2'd1;
						open_n = 1'b0;
					end
					phase_n  = PH_SEARCH;
					win_n[0] = 8'd0;
					win_n[1] = 8'd0;
					win_n[2] = b;
					fill_n   = 2'd1;
				end else begin
					cnt = (b == LEN_FULL) ? CNT_FULL : b - 8'd2;
					if (type_q == TYPE_HEADER && !open_q) begin
						open_n = 1'b1;
						fcnt_n = fcnt_q + 16'd1;
					end
					left_n  = cnt;
					pos_n   = 8'd0;
					sum_n   = 8'd0;
					phase_n = (cnt != 8'd0) ? PH_DATA : PH_CHECK;
					trunc   = tend;
				end
			end
			PH_DATA: begin
				bun.rec[nr] = mk(EV_PAYLOAD, type_q, b, pos_q, pos_q + left_q, 1'b0, 1'b0,
					open_q, fcnt_q);
				nr = nr + 2'd1;
				sum_n  = sum_q + b;
				pos_n  = pos_q + 8'd1;
				left_n = left_q - 8'd1;
				if (left_n == 8'd0) phase_n = PH_CHECK;
				trunc = tend;
			end
			PH_CHECK: begin
				bun.rec[nr] = mk(EV_COMPLETE, type_q, 8'd0, 8'd0, pos_q, (sum_q + b) == 8'd0,
					!open_q, open_q, fcnt_q);
				nr = nr + 2'd1;
				if (open_q && type_q == TYPE_EOF) open_n = 1'b0;
				phase_n = PH_SEARCH;
				fill_n  = 2'd0;
				if (tend && open_n) begin
					bun.rec[nr] = mk(EV_TAPE_END, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1,
						fcnt_q);
					nr = nr + 2'd1;
				end
			end
			default: begin
				// sliding window search, unknown codes included
				hit = (fill_q == 2'd3) && (win_q[0] == pilot_value) &&
					(win_q[1] == pilot_value) && (win_q[2] == sync_first) &&
					(b == sync_second);
				if (hit) begin
					phase_n = PH_TYPE;
					fill_n  = 2'd0;
					type_n  = 8'd0;
					left_n  = 8'd0;
					pos_n   = 8'd0;
				end else begin
					phase_n  = PH_SEARCH;
					win_n[0] = win_q[1];
					win_n[1] = win_q[2];
					win_n[2] = b;
					if (fill_q != 2'd3) fill_n = fill_q + 2'd1;
				end
				if (tend && open_q) begin
					bun.rec[nr] = mk(hit ? EV_CORRUPT : EV_TAPE_END, 8'd0, 8'd0, 8'd0, 8'd0,
						1'b0, 1'b0, 1'b1, fcnt_q);
					nr = nr + 2'd1;
				end
			end
		endcase

		// tape ended inside a block
		if (trunc) begin
			bun.rec[nr] = mk(EV_TRUNCATED, type_n, 8'd0, 8'd0, pos_n + left_n, 1'b0, !open_n,
				open_n, fcnt_n);
			nr = nr + 2'd1;
			if (open_n) begin
				if (type_n == TYPE_EOF) begin
					open_n = 1'b0;
				end else begin
					bun.rec[nr] = mk(EV_TAPE_END, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1,
						fcnt_n);
					nr = nr + 2'd1;
				end
			end
		end

		if (nr != 2'd0) bun.rec[nr - 2'd1].last_of_run = 1'b1;
		bun.cnt = nr;

		// end of tape returns everything to reset
		if (tend) begin
			phase_n = PH_SEARCH;
			win_n[0] = 8'd0;
			win_n[1] = 8'd0;
			win_n[2] = 8'd0;
			fill_n  = 2'd0;
			type_n  = 8'd0;
			left_n  = 8'd0;
			pos_n   = 8'd0;
			sum_n   = 8'd0;
			open_n  = 1'b0;
			fcnt_n  = 16'd0;
		end
	end

	// deframer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEARCH;
			win_q[0] <= 8'd0;
			win_q[1] <= 8'd0;
			win_q[2] <= 8'd0;
			fill_q   <= 2'd0;
			type_q   <= 8'd0;
			left_q   <= 8'd0;
			pos_q    <= 8'd0;
			sum_q    <= 8'd0;
			open_q   <= 1'b0;
			fcnt_q   <= 16'd0;
		end else if (accept) begin
			phase_q <= phase_n;
			win_q   <= win_n;
			fill_q  <= fill_n;
			type_q  <= type_n;
			left_q  <= left_n;
			pos_q   <= pos_n;
			sum_q   <= sum_n;
			open_q  <= open_n;
			fcnt_q  <= fcnt_n;
		end
	end

	assign wr.push = accept && (nr != 2'd0);
	assign wr.data = bun;

endmodule

>>> sv/cbd_back.sv
module cbd_back
	import cbd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  bundle_t head,
	input  q_stat_t stat,
	output logic    pop,
	cbd_out_if.source out_ch
);

	logic [1:0] idx_q;
	rec_t       cur;
	logic       last;
	logic       take;

	assign cur  = head.rec[idx_q];
	assign last = (idx_q == head.cnt - 2'd1);
	assign take = out_ch.valid && out_ch.ready;
	assign pop  = take && last;

	// walk the words of the head bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (take) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

	assign out_ch.valid         = !stat.empty;
	assign out_ch.event_res     = cur.event_res;
	assign out_ch.block_type    = cur.block_type;
	assign out_ch.payload_byte  = cur.payload_byte;
	assign out_ch.payload_index = cur.payload_index;
	assign out_ch.payload_count = cur.payload_count;
	assign out_ch.checksum_good = cur.checksum_good;
	assign out_ch.orphan        = cur.orphan;
	assign out_ch.in_file       = cur.in_file;
	assign out_ch.file_index    = cur.file_index;
	assign out_ch.last_of_run   = cur.last_of_run;

endmodule

>>> sv/cassette_block_deframer.sv
// Cassette block deframer. Tape bytes enter on in_ch, one byte at a time, and
// are matched against pilot, pilot, sync_first, sync_second to find block
// starts; type, length, payload and checksum bytes follow. Each byte yields
// zero to three result words on out_ch (payload, block end, truncation,
// corrupt block, tape ended inside a file), the last one flagged by
// last_of_run. Input runs at one byte per cycle while the result queue has
// room; the output side drains one word per cycle while out_ch.ready is high,
// so a byte that causes several words holds the output for each of them, and
// the QUEUE_DEPTH-entry queue between classifier and output absorbs the
// difference. Registers pilot_value, sync_first and sync_second sit at byte
// addresses 0, 4 and 8 of the APB port and are to be written only while the
// block is idle; the block itself does not enforce this.
`include "cassette_block_deframer_defines.svh"

module cassette_block_deframer
	import cbd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	cbd_in_if.sink      in_ch,
	cbd_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] pilot_q;
	logic [7:0] sync1_q;
	logic [7:0] sync2_q;
	logic       cfg_wr;

	q_wr_t      wr;
	q_stat_t    stat;
	bundle_t    head;
	logic       pop;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pilot_q <= PILOT_RESET;
			sync1_q <= SYNC1_RESET;
			sync2_q <= SYNC2_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_PILOT: pilot_q <= pwdata[7:0];
				REG_SYNC1: sync1_q <= pwdata[7:0];
				REG_SYNC2: sync2_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[3:2])
			REG_PILOT: prdata = {24'd0, pilot_q};
			REG_SYNC1: prdata = {24'd0, sync1_q};
			REG_SYNC2: prdata = {24'd0, sync2_q};
			default:   prdata = 32'd0;
		endcase
	end

	cbd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pilot_value (pilot_q),
		.sync_first  (sync1_q),
		.sync_second (sync2_q),
		.in_ch       (in_ch),
		.stat        (stat),
		.wr          (wr)
	);

	cbd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	cbd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.stat   (stat),
		.pop    (pop),
		.out_ch (out_ch)
	);

	// a pushed bundle leaves the queue non-empty
	`CBD_CHECK_NEXT(a_push_fills, wr.push, !stat.empty, "queue empty after push")
	// a run continues until its last word is taken
	`CBD_CHECK_NEXT(a_run_holds, out_ch.valid && out_ch.ready && !out_ch.last_of_run,
		out_ch.valid, "result run broken off")
	// payload position lies inside the declared length
	`CBD_CHECK_NOW(a_index_in_range, out_ch.valid && out_ch.event_res == EV_PAYLOAD,
		out_ch.payload_index < out_ch.payload_count, "payload index past count")

endmodule

>>> tb/sv/cassette_block_deframer_tb.sv
`timescale 1ns / 100ps

module cassette_block_deframer_tb
	import cbd_pkg::*;
();

	// deframer phases as seen by the predictor
	typedef enum logic [2:0] {
		SEEK_SYNC,
		READ_TYPE,
		READ_LEN,
		READ_DATA,
		READ_SUM
	} deframe_state_t;

	// one directed tape byte with its hand-written result, if any
	typedef struct packed {
		logic [7:0] tape_byte;
		logic       tape_end;
		int         typed_count;
		rec_t       want;
	} tape_row_t;

	// typed_count value that defers to the predictor
	localparam int AUTO = -1;
	localparam int DIRECTED_ROWS = 22;
	localparam int MAX_REPORTS = 10;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	cbd_in_if  tape_ch ();
	cbd_out_if event_ch ();

	cassette_block_deframer uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (tape_ch),
		.out_ch  (event_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// register copies
	logic [7:0] cfg_pilot;
	logic [7:0] cfg_sync1;
	logic [7:0] cfg_sync2;

	// deframer state copy
	deframe_state_t dstate;
	logic [7:0]     win [3];
	logic [1:0]     win_fill;
	logic [7:0]     blk_type;
	logic [7:0]     remain;
	logic [7:0]     pos;
	logic [7:0]     sum;
	logic           file_on;
	logic [15:0]    file_no;

	rec_t byte_results[$];
	rec_t expected_events[$];

	tape_row_t directed_tape [DIRECTED_ROWS];

	int fail_count;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	int full_blocks;

	function automatic rec_t mk_event(logic [2:0] ev, logic [7:0] typ, logic [7:0] pb,
		logic [7:0] pidx, logic [7:0] pcnt, logic good, logic orph, logic inf,
		logic [15:0] fidx, logic last);
		rec_t r;
		r.event_res     = ev;
		r.block_type    = typ;
		r.payload_byte  = pb;
		r.payload_index = pidx;
		r.payload_count = pcnt;
		r.checksum_good = good;
		r.orphan        = orph;
		r.in_file       = inf;
		r.file_index    = fidx;
		r.last_of_run   = last;
		return r;
	endfunction

	function automatic string event_text(rec_t r);
		return $sformatf({"ev=%0d type=%02h byte=%02h idx=%0d cnt=%0d good=%b ",
			"orphan=%b in_file=%b file=%0d last=%b"}, r.event_res, r.block_type,
			r.payload_byte, r.payload_index, r.payload_count, r.checksum_good,
			r.orphan, r.in_file, r.file_index, r.last_of_run);
	endfunction

	function void log_failure(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%s", msg);
	endfunction

	function void clear_deframer();
		dstate   = SEEK_SYNC;
		win[0]   = 8'd0;
		win[1]   = 8'd0;
		win[2]   = 8'd0;
		win_fill = 2'd0;
		blk_type = 8'd0;
		remain   = 8'd0;
		pos      = 8'd0;
		sum      = 8'd0;
		file_on  = 1'b0;
		file_no  = 16'd0;
	endfunction

	// file number only shows while the block is in a file
	function void add_event(logic [2:0] ev, logic [7:0] typ, logic [7:0] pb,
		logic [7:0] pidx, logic [7:0] pcnt, logic good, logic orph, logic inf);
		byte_results = {byte_results, mk_event(ev, typ, pb, pidx, pcnt, good, orph, inf,
			inf ? file_no : 16'd0, 1'b0)};
	endfunction

	// tape ran out inside a block; an eof block still closes its file
	function void end_truncated();
		add_event(EV_TRUNCATED, blk_type, 8'd0, 8'd0, pos + remain, 1'b0, !file_on, file_on);
		if (file_on) begin
			if (blk_type == TYPE_EOF)
				file_on = 1'b0;
			else
				add_event(EV_TAPE_END, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1);
		end
	endfunction

	// words caused by one tape byte, left in byte_results
	function void deframe_byte(logic [7:0] b, logic e);
		logic       hit;
		logic [7:0] cnt;
		byte_results.delete();
		case (dstate)
			READ_TYPE: begin
				blk_type = b;
				dstate = READ_LEN;
				if (e && file_on)
					add_event(EV_CORRUPT, blk_type, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1);
			end
			READ_LEN: begin
				if (b == LEN_BAD) begin
					// malformed length drops the block and restarts the search on it
					if (file_on) begin
						add_event(EV_CORRUPT, blk_type, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1);
						file_on = 1'b0;
					end
					dstate = SEEK_SYNC;
					win[0] = 8'd0;
					win[1] = 8'd0;
					win[2] = b;
					win_fill = 2'd1;
				end else begin
					cnt = (b == LEN_FULL) ? CNT_FULL : b - 8'd2;
					if (blk_type == TYPE_HEADER && !file_on) begin
						file_on = 1'b1;
						file_no = file_no + 16'd1;
					end
					remain = cnt;
					pos = 8'd0;
					sum = 8'd0;
					dstate = (cnt != 8'd0) ? READ_DATA : READ_SUM;
					if (e)
						end_truncated();
				end
			end
			READ_DATA: begin
				add_event(EV_PAYLOAD, blk_type, b, pos, pos + remain, 1'b0, 1'b0, file_on);
				sum = sum + b;
				pos = pos + 8'd1;
				remain = remain - 8'd1;
				if (remain == 8'd0)
					dstate = READ_SUM;
				if (e)
					end_truncated();
			end
			READ_SUM: begin
				add_event(EV_COMPLETE, blk_type, 8'd0, 8'd0, pos, (sum + b) == 8'd0,
					!file_on, file_on);
				if (file_on && blk_type == TYPE_EOF)
					file_on = 1'b0;
				dstate = SEEK_SYNC;
				win_fill = 2'd0;
				if (e && file_on)
					add_event(EV_TAPE_END, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1);
			end
			default: begin
				hit = win_fill == 2'd3 && win[0] == cfg_pilot && win[1] == cfg_pilot &&
					win[2] == cfg_sync1 && b == cfg_sync2;
				if (hit) begin
					dstate = READ_TYPE;
					win_fill = 2'd0;
					blk_type = 8'd0;
					remain = 8'd0;
					pos = 8'd0;
				end else begin
					dstate = SEEK_SYNC;
					win[0] = win[1];
					win[1] = win[2];
					win[2] = b;
					if (win_fill < 2'd3)
						win_fill = win_fill + 2'd1;
				end
				if (e && file_on)
					add_event(hit ? EV_CORRUPT : EV_TAPE_END, 8'd0, 8'd0, 8'd0, 8'd0,
						1'b0, 1'b0, 1'b1);
			end
		endcase
		if (byte_results.size() > 0)
			byte_results[byte_results.size() - 1].last_of_run = 1'b1;
		if (e)
			clear_deframer();
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

	// result side ready, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles = hold_cycles - 1;
			event_ch.ready <= 1'b0;
		end else begin
			event_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// compare every accepted word with the oldest expected one
	always @(posedge clk) begin
		rec_t got;
		rec_t want;
		if (arst_n && event_ch.valid && event_ch.ready) begin
			got = mk_event(event_ch.event_res, event_ch.block_type, event_ch.payload_byte,
				event_ch.payload_index, event_ch.payload_count, event_ch.checksum_good,
				event_ch.orphan, event_ch.in_file, event_ch.file_index,
				event_ch.last_of_run);
			if (expected_events.size() == 0) begin
				log_failure({"unexpected word: ", event_text(got)});
			end else begin
				want = expected_events.pop_front();
				if (got !== want)
					log_failure({"mismatch\n  expected ", event_text(want),
						"\n  actual   ", event_text(got)});
			end
		end
	end

	// offer one byte, wait for it to be taken, then queue its results
	task automatic send_tape_byte(logic [7:0] b, logic e, int typed_count, rec_t want);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			tape_ch.valid <= 1'b0;
			@(negedge clk);
		end
		tape_ch.valid     <= 1'b1;
		tape_ch.tape_byte <= b;
		tape_ch.tape_end  <= e;
		do @(posedge clk); while (!tape_ch.ready);
		deframe_byte(b, e);
		if (typed_count == AUTO) begin
			foreach (byte_results[i])
				expected_events = {expected_events, byte_results[i]};
		end else if (typed_count == 1) begin
			expected_events = {expected_events, want};
		end
	endtask

	// random byte that now and then ends the tape
	task automatic send_random_byte(logic [7:0] b);
		send_tape_byte(b, $urandom_range(0, 59) == 0, AUTO, '0);
	endtask

	// sender goes quiet until every expected word has come out
	task automatic wait_drained();
		@(negedge clk);
		tape_ch.valid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// apb write then read back
	task automatic write_register(logic [1:0] idx, logic [7:0] value);
		logic [31:0] rd;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_PILOT: cfg_pilot = value;
			REG_SYNC1: cfg_sync1 = value;
			REG_SYNC2: cfg_sync2 = value;
			default: ;
		endcase
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== {24'd0, value})
			log_failure($sformatf("register %0d read back %08h, expected %02h", idx, rd, value));
	endtask

	// mostly well-formed blocks with random content, some noise and breakage
	task automatic send_random_blocks(int n_items);
		int         sent;
		int         noise;
		int         broken_at;
		int         r;
		int         cnt;
		logic [7:0] typ;
		logic [7:0] len;
		logic [7:0] b;
		logic [7:0] run;
		sent = 0;
		while (sent < n_items) begin
			// noise between blocks
			noise = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
			repeat (noise) send_random_byte(8'($urandom_range(0, 255)));

			// start pattern, broken now and then
			broken_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 4;
			for (int i = 0; i < 4; i++) begin
				if (i == broken_at)
					b = 8'($urandom_range(0, 255));
				else if (i < 2)
					b = cfg_pilot;
				else if (i == 2)
					b = cfg_sync1;
				else
					b = cfg_sync2;
				send_random_byte(b);
			end
			sent += 4;

			// block type
			r = $urandom_range(0, 9);
			if (r < 3)
				typ = TYPE_HEADER;
			else if (r < 7)
				typ = 8'h01;
			else if (r < 9)
				typ = TYPE_EOF;
			else
				typ = 8'($urandom_range(0, 255));
			send_random_byte(typ);

			// length: mostly short, a few full and malformed
			r = $urandom_range(0, 39);
			if (r == 0 && full_blocks < 2) begin
				len = LEN_FULL;
				full_blocks++;
			end else if (r < 4) begin
				len = LEN_BAD;
			end else if (r == 4) begin
				len = 8'($urandom_range(13, 40));
			end else begin
				len = 8'($urandom_range(2, 12));
			end
			send_random_byte(len);
			sent += 2;

			// payload and checksum
			if (len != LEN_BAD) begin
				cnt = (len == LEN_FULL) ? 254 : len - 2;
				run = 8'd0;
				repeat (cnt) begin
					b = 8'($urandom_range(0, 255));
					run = run + b;
					send_random_byte(b);
				end
				if ($urandom_range(0, 3) != 0)
					send_random_byte(~run + 8'd1);
				else
					send_random_byte(8'($urandom_range(0, 255)));
				sent += cnt + 1;
			end
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		tape_ch.valid     = 1'b0;
		tape_ch.tape_byte = 8'd0;
		tape_ch.tape_end  = 1'b0;
		event_ch.ready    = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = 4'd0;
		pwdata            = 32'd0;
		fail_count        = 0;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;
		hold_cycles       = 0;
		full_blocks       = 0;
		cfg_pilot         = PILOT_RESET;
		cfg_sync1         = SYNC1_RESET;
		cfg_sync2         = SYNC2_RESET;
		clear_deframer();

		// header block of one byte, then the tape ends while searching in the file
		directed_tape[0]  = '{PILOT_RESET, 1'b0, 0, '0};
		directed_tape[1]  = '{PILOT_RESET, 1'b0, 0, '0};
		directed_tape[2]  = '{SYNC1_RESET, 1'b0, 0, '0};
		directed_tape[3]  = '{SYNC2_RESET, 1'b0, 0, '0};
		directed_tape[4]  = '{TYPE_HEADER, 1'b0, 0, '0};
		directed_tape[5]  = '{8'h03, 1'b0, 0, '0};
		directed_tape[6]  = '{8'hFF, 1'b0, 1, mk_event(EV_PAYLOAD, TYPE_HEADER, 8'hFF,
			8'd0, 8'd1, 1'b0, 1'b0, 1'b1, 16'd1, 1'b1)};
		directed_tape[7]  = '{8'h01, 1'b0, 1, mk_event(EV_COMPLETE, TYPE_HEADER, 8'h00,
			8'd0, 8'd1, 1'b1, 1'b0, 1'b1, 16'd1, 1'b1)};
		directed_tape[8]  = '{8'h00, 1'b1, 1, mk_event(EV_TAPE_END, 8'h00, 8'h00,
			8'd0, 8'd0, 1'b0, 1'b0, 1'b1, 16'd1, 1'b1)};
		// malformed length outside a file, reused as the first pilot
		directed_tape[9]  = '{PILOT_RESET, 1'b0, 0, '0};
		directed_tape[10] = '{PILOT_RESET, 1'b0, 0, '0};
		directed_tape[11] = '{SYNC1_RESET, 1'b0, 0, '0};
		directed_tape[12] = '{SYNC2_RESET, 1'b0, 0, '0};
		directed_tape[13] = '{TYPE_HEADER, 1'b0, 0, '0};
		directed_tape[14] = '{LEN_BAD, 1'b0, 0, '0};
		directed_tape[15] = '{PILOT_RESET, 1'b0, 0, '0};
		directed_tape[16] = '{SYNC1_RESET, 1'b0, 0, '0};
		directed_tape[17] = '{SYNC2_RESET, 1'b0, 0, '0};
		// orphan full-length data block cut short by the tape end
		directed_tape[18] = '{8'h01, 1'b0, 0, '0};
		directed_tape[19] = '{LEN_FULL, 1'b0, 0, '0};
		directed_tape[20] = '{8'hAB, 1'b0, 1, mk_event(EV_PAYLOAD, 8'h01, 8'hAB,
			8'd0, CNT_FULL, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1)};
		directed_tape[21] = '{8'h54, 1'b1, AUTO, '0};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// no idling: directed bytes, long result hold-off, sender pause
		foreach (directed_tape[i])
			send_tape_byte(directed_tape[i].tape_byte, directed_tape[i].tape_end,
				directed_tape[i].typed_count, directed_tape[i].want);
		send_random_blocks(30);
		hold_cycles = 120;
		send_random_blocks(25);
		wait_drained();
		send_random_blocks(25);

		// extreme settings, sender idling
		wait_drained();
		write_register(REG_PILOT, 8'h00);
		write_register(REG_SYNC1, 8'hFF);
		write_register(REG_SYNC2, 8'h00);
		send_idle_pct = 51;
		send_random_blocks(75);

		// opposite extremes, receiver stalling
		wait_drained();
		write_register(REG_PILOT, 8'hFF);
		write_register(REG_SYNC1, 8'h00);
		write_register(REG_SYNC2, 8'hFF);
		send_idle_pct = 0;
		recv_stall_pct = 51;
		send_random_blocks(75);

		// random settings, both sides idling
		wait_drained();
		write_register(REG_PILOT, 8'($urandom_range(0, 255)));
		write_register(REG_SYNC1, 8'($urandom_range(0, 255)));
		write_register(REG_SYNC2, 8'($urandom_range(0, 255)));
		send_idle_pct = 17;
		recv_stall_pct = 17;
		send_random_blocks(75);

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && expected_events.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
